// ----- design/rlnp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlnp_pkg
// Types, character codes and helper functions of the response line number
// parser.
// ----------------------------------------------------------------------------
package rlnp_pkg;

   // Parser phase within one response buffer.
   typedef enum logic [3:0] {
      PH_FIRST  = 4'b0001,
      PH_STATUS = 4'b0010,
      PH_TOKENS = 4'b0100,
      PH_DRAIN  = 4'b1000
   } phase_type;

   // Progress through the prefix of one token.
   typedef enum logic [5:0] {
      PS_START  = 6'b000001,
      PS_SIGNED = 6'b000010,
      PS_ZERO   = 6'b000100,
      PS_HEX0X  = 6'b001000,
      PS_DIGITS = 6'b010000,
      PS_DONE   = 6'b100000
   } prefix_type;

   typedef enum logic [1:0] {
      BASE_DEC = 2'd0,
      BASE_OCT = 2'd1,
      BASE_HEX = 2'd2
   } base_type;

   localparam logic [1:0] STATUS_NONE = 2'd0;
   localparam logic [1:0] STATUS_POS  = 2'd1;
   localparam logic [1:0] STATUS_NEG  = 2'd2;

   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_O     = 8'h4F;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_SP    = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LX    = 8'h78;
   localparam logic [7:0] CHAR_UX    = 8'h58;

   localparam logic [63:0] SAT_POS32 = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] SAT_NEG32 = 64'hFFFF_FFFF_8000_0000;
   localparam logic [63:0] MAG_NEG32 = 64'h0000_0000_8000_0000;
   localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

   // Digit value of a character; bit 4 is set when it is a hex digit.
   function automatic logic [4:0] digit_of(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic [4:0] radix_of(input base_type base);
      logic [4:0] r;
      case (base)
         BASE_OCT: r = 5'd8;
         BASE_HEX: r = 5'd16;
         default:  r = 5'd10;
      endcase
      return r;
   endfunction

   // acc * radix + d; bit 64 flags a result that no longer fits 64 bits.
   function automatic logic [64:0] acc_step(input logic [63:0] acc,
                                            input base_type base,
                                            input logic [3:0] d);
      logic [67:0] wide;
      logic [67:0] full;
      wide = {4'd0, acc};
      case (base)
         BASE_OCT: full = (wide << 3) + {64'd0, d};
         BASE_HEX: full = (wide << 4) + {64'd0, d};
         default:  full = (wide << 3) + (wide << 1) + {64'd0, d};
      endcase
      return {(|full[67:64]), full[63:0]};
   endfunction

   // Final value of a token, with 32-bit saturation where it applies.
   function automatic logic [63:0] tok_value(input logic [63:0] m,
                                             input logic ovf,
                                             input logic minus,
                                             input logic sat32);
      logic [63:0] r;
      if (sat32) begin
         if (minus) begin
            r = (ovf || m > MAG_NEG32) ? SAT_NEG32 : 64'd0 - m;
         end else begin
            r = (ovf || m > SAT_POS32) ? SAT_POS32 : m;
         end
      end else if (ovf) begin
         r = ALL_ONES;
      end else begin
         r = minus ? 64'd0 - m : m;
      end
      return r;
   endfunction

endpackage

// ----- design/response_line_number_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// response_line_number_parser_top
// Parses the numbers on the first line of a response buffer, one byte per
// request.
// ----------------------------------------------------------------------------
// Usage: each request on the req_ channel carries one byte of a response
// buffer, with req_end_of_buffer set on the buffer's last byte. Only the
// first line is parsed; a leading 'O' or 'E' selects positive or negative
// status and every space-separated token after the status word produces one
// result on the rsp_ channel. Bytes after the first newline are dropped up
// to the end of the buffer.
// Results are registered: a result is written to the output register as
// the request that completes it is accepted. Throughput is one request per
// cycle while req_ready is high; the 64-bit accumulator step is combinational.
// Requests that produce no result pass through without touching rsp_.
// When the receiver stalls with a result waiting, the result is held and
// req_ready stays low until rsp_ready returns; req_ready follows rsp_ready
// in the same cycle, so a full register still takes a request per cycle.
// Reset (synchronous, active high) returns the parser to the start of a
// buffer with no status and empties the output register.
// ----------------------------------------------------------------------------
module response_line_number_parser_top
   import rlnp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   input  logic        req_end_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_resp_status,
   output logic        rsp_has_value,
   output logic [63:0] rsp_token_value,
   output logic [7:0]  rsp_token_number,
   output logic        rsp_line_done
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  status_ff, status_in;
   logic [63:0] acc_ff, acc_in;
   logic        ovf_ff, ovf_in;
   logic        minus_ff, minus_in;
   base_type    base_ff, base_in;
   prefix_type  prefix_ff, prefix_in;
   logic        hex_ff, hex_in;
   logic        pwz_ff, pwz_in;
   logic [7:0]  count_ff, count_in;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_status_ff;
   logic        out_hv_ff;
   logic [63:0] out_value_ff;
   logic [7:0]  out_number_ff;
   logic        out_done_ff;

   // Token state after feeding the current byte.
   logic [63:0] f_acc;
   logic        f_ovf, f_minus, f_hex, f_pwz;
   base_type    f_base;
   prefix_type  f_prefix;

   logic [4:0]  dig;
   logic        do_acc;
   base_type    acc_base;
   logic [64:0] step;
   logic        dec_ok;
   logic        accept;
   logic        emit;
   logic        emit_hv;
   logic        emit_done;
   logic [63:0] emit_value;
   logic [7:0]  emit_number;
   logic [63:0] fed_value;
   logic        is_nl, is_sp, eob;

   logic [7:0]  c;

   assign c      = req_char_in;
   assign eob    = req_end_of_buffer;
   assign is_nl  = (c == CHAR_NL);
   assign is_sp  = (c == CHAR_SP);
   assign dig    = digit_of(c);
   assign dec_ok = dig[4] && (dig[3:0] < 4'd10);

   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // One character through the token prefix and digit state.
   always_comb begin
      f_acc    = acc_ff;
      f_ovf    = ovf_ff;
      f_minus  = minus_ff;
      f_base   = base_ff;
      f_prefix = prefix_ff;
      f_hex    = hex_ff;
      f_pwz    = (c == CHAR_ZERO);
      do_acc   = 1'b0;
      acc_base = BASE_DEC;
      if (c == CHAR_LX && pwz_ff) begin
         f_hex = 1'b1;
      end
      case (prefix_ff)
         PS_START, PS_SIGNED: begin
            if (prefix_ff == PS_START &&
                (c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF || c == CHAR_CR)) begin
               f_prefix = prefix_ff;
            end else if (prefix_ff == PS_START && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
               f_minus  = (c == CHAR_MINUS);
               f_prefix = PS_SIGNED;
            end else if (status_ff != STATUS_NEG && c == CHAR_ZERO) begin
               f_prefix = PS_ZERO;
            end else if (dec_ok) begin
               do_acc   = 1'b1;
               acc_base = BASE_DEC;
               f_base   = BASE_DEC;
               f_prefix = PS_DIGITS;
            end else begin
               f_prefix = PS_DONE;
            end
         end
         PS_ZERO: begin
            if (c == CHAR_LX || c == CHAR_UX) begin
               f_prefix = PS_HEX0X;
            end else if (dig[4] && dig[3:0] < 4'd8) begin
               do_acc   = 1'b1;
               acc_base = BASE_OCT;
               f_base   = BASE_OCT;
               f_prefix = PS_DIGITS;
            end else begin
               f_prefix = PS_DONE;
            end
         end
         PS_HEX0X: begin
            if (dig[4]) begin
               do_acc   = 1'b1;
               acc_base = BASE_HEX;
               f_base   = BASE_HEX;
               f_prefix = PS_DIGITS;
            end else begin
               f_prefix = PS_DONE;
            end
         end
         PS_DIGITS: begin
            if (dig[4] && {1'b0, dig[3:0]} < radix_of(base_ff)) begin
               do_acc   = 1'b1;
               acc_base = base_ff;
            end else begin
               f_prefix = PS_DONE;
            end
         end
         default: begin
            f_prefix = prefix_ff;
         end
      endcase
      step = acc_step(acc_ff, acc_base, dig[3:0]);
      if (do_acc && !ovf_ff) begin
         if (step[64]) begin
            f_ovf = 1'b1;
         end else begin
            f_acc = step[63:0];
         end
      end
   end

   // A newline or space leaves the token untouched, so the fed state is only
   // different from the stored one for other characters.
   assign fed_value = (is_nl || is_sp)
                    ? tok_value(acc_ff, ovf_ff, minus_ff, (status_ff == STATUS_NEG) || hex_ff)
                    : tok_value(f_acc, f_ovf, f_minus, (status_ff == STATUS_NEG) || f_hex);

   always_comb begin
      phase_in    = phase_ff;
      status_in   = status_ff;
      acc_in      = acc_ff;
      ovf_in      = ovf_ff;
      minus_in    = minus_ff;
      base_in     = base_ff;
      prefix_in   = prefix_ff;
      hex_in      = hex_ff;
      pwz_in      = pwz_ff;
      count_in    = count_ff;
      emit        = 1'b0;
      emit_hv     = 1'b1;
      emit_value  = 64'd0;
      emit_done   = 1'b0;
      emit_number = count_ff;
      case (phase_ff)
         PH_FIRST: begin
            count_in    = 8'd0;
            emit_number = 8'd0;
            acc_in      = 64'd0;
            ovf_in      = 1'b0;
            minus_in    = 1'b0;
            base_in     = BASE_DEC;
            prefix_in   = PS_START;
            hex_in      = 1'b0;
            pwz_in      = 1'b0;
            if (c == CHAR_O || c == CHAR_E) begin
               status_in = (c == CHAR_O) ? STATUS_POS : STATUS_NEG;
               if (eob) begin
                  emit      = 1'b1;
                  emit_done = 1'b1;
               end else begin
                  phase_in = PH_STATUS;
               end
            end else begin
               emit      = 1'b1;
               emit_hv   = 1'b0;
               emit_done = 1'b1;
               phase_in  = eob ? PH_FIRST : PH_DRAIN;
            end
         end
         PH_STATUS: begin
            if (is_nl) begin
               emit      = 1'b1;
               emit_done = 1'b1;
               phase_in  = eob ? PH_FIRST : PH_DRAIN;
            end else if (is_sp) begin
               acc_in    = 64'd0;
               ovf_in    = 1'b0;
               minus_in  = 1'b0;
               base_in   = BASE_DEC;
               prefix_in = PS_START;
               hex_in    = 1'b0;
               pwz_in    = 1'b0;
               if (eob) begin
                  emit      = 1'b1;
                  emit_done = 1'b1;
                  phase_in  = PH_FIRST;
               end else begin
                  phase_in = PH_TOKENS;
               end
            end else if (eob) begin
               emit      = 1'b1;
               emit_done = 1'b1;
               phase_in  = PH_FIRST;
            end
         end
         PH_TOKENS: begin
            emit_value = fed_value;
            if (is_nl) begin
               emit      = 1'b1;
               emit_done = 1'b1;
               phase_in  = eob ? PH_FIRST : PH_DRAIN;
            end else if (is_sp) begin
               emit      = 1'b1;
               emit_done = eob;
               if (count_ff != 8'hFF) begin
                  count_in = count_ff + 8'd1;
               end
               acc_in    = 64'd0;
               ovf_in    = 1'b0;
               minus_in  = 1'b0;
               base_in   = BASE_DEC;
               prefix_in = PS_START;
               hex_in    = 1'b0;
               pwz_in    = 1'b0;
               if (eob) begin
                  phase_in = PH_FIRST;
               end
            end else begin
               acc_in    = f_acc;
               ovf_in    = f_ovf;
               minus_in  = f_minus;
               base_in   = f_base;
               prefix_in = f_prefix;
               hex_in    = f_hex;
               pwz_in    = f_pwz;
               if (eob) begin
                  emit      = 1'b1;
                  emit_done = 1'b1;
                  phase_in  = PH_FIRST;
               end
            end
         end
         PH_DRAIN: begin
            if (eob) begin
               phase_in = PH_FIRST;
            end
         end
         default: begin
            phase_in = PH_FIRST;
         end
      endcase
   end

   // The output register fills on a request that produces a result and
   // empties when the receiver takes it.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (accept && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   logic take;
   assign take = accept && (emit ? (!out_valid_ff || rsp_ready) : 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         status_ff    <= STATUS_NONE;
         acc_ff       <= 64'd0;
         ovf_ff       <= 1'b0;
         minus_ff     <= 1'b0;
         base_ff      <= BASE_DEC;
         prefix_ff    <= PS_START;
         hex_ff       <= 1'b0;
         pwz_ff       <= 1'b0;
         count_ff     <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            phase_ff  <= phase_in;
            status_ff <= status_in;
            acc_ff    <= acc_in;
            ovf_ff    <= ovf_in;
            minus_ff  <= minus_in;
            base_ff   <= base_in;
            prefix_ff <= prefix_in;
            hex_ff    <= hex_in;
            pwz_ff    <= pwz_in;
            count_ff  <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         out_status_ff <= status_in;
         out_hv_ff     <= emit_hv;
         out_value_ff  <= emit_value;
         out_number_ff <= emit_number;
         out_done_ff   <= emit_done;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_resp_status  = out_status_ff;
   assign rsp_has_value    = out_hv_ff;
   assign rsp_token_value  = out_value_ff;
   assign rsp_token_number = out_number_ff;
   assign rsp_line_done    = out_done_ff;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the response line number parser. A short table of
// hand-written requests comes first, then randomly built response buffers,
// mostly well-formed lines of numeric tokens in every base with noise mixed
// in. Each accepted request runs through a local parser model, and every
// result is compared with the oldest expected one. Both channels idle at
// random.
// ----------------------------------------------------------------------------
module tb_top
   import rlnp_pkg::*;
();

   localparam int CLK_PERIOD    = 8;
   localparam int RESET_CYCLES  = 8;
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int IDLE_LIMIT    = 1000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int MAX_REPORTS   = 100;

   typedef struct packed {
      logic [1:0]  status;
      logic        has_value;
      logic [63:0] value;
      logic [7:0]  number;
      logic        done;
   } line_result_type;

   typedef struct packed {
      logic [7:0]      ch;
      logic            eob;
      logic            typed;
      line_result_type res;
   } stim_row_type;

   localparam line_result_type NO_STATUS_RESULT = '{STATUS_NONE, 1'b0, 64'd0, 8'd0, 1'b1};
   localparam line_result_type NEG_ZERO_RESULT  = '{STATUS_NEG, 1'b1, 64'd0, 8'd0, 1'b1};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_in = 8'd0;
   logic        req_end_of_buffer = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_resp_status;
   logic        rsp_has_value;
   logic [63:0] rsp_token_value;
   logic [7:0]  rsp_token_number;
   logic        rsp_line_done;

   stim_row_type    directed_rows [DIRECTED_ROWS];
   stim_row_type    stim_rows [$];
   logic [7:0]      line_bytes [$];
   line_result_type expected_results [$];
   int              mismatch_count = 0;
   bit              quiet = 1'b0;

   // Parser model state.
   phase_type   p_phase;
   logic [1:0]  p_status;
   logic [63:0] p_acc;
   logic        p_ovf;
   logic        p_minus;
   base_type    p_base;
   prefix_type  p_prefix;
   logic        p_hex_seen;
   logic        p_prev_zero;
   logic [7:0]  p_count;

   always #(CLK_PERIOD / 2) clock = ~clock;

   response_line_number_parser_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_in       (req_char_in),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_resp_status   (rsp_resp_status),
      .rsp_has_value     (rsp_has_value),
      .rsp_token_value   (rsp_token_value),
      .rsp_token_number  (rsp_token_number),
      .rsp_line_done     (rsp_line_done)
   );

   // ------------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------------
   function automatic int char_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      return 99;
   endfunction

   function automatic int cur_radix();
      case (p_base)
         BASE_OCT: return 8;
         BASE_HEX: return 16;
         default:  return 10;
      endcase
   endfunction

   task automatic clear_token();
      p_acc = 64'd0;
      p_ovf = 1'b0;
      p_minus = 1'b0;
      p_base = BASE_DEC;
      p_prefix = PS_START;
      p_hex_seen = 1'b0;
      p_prev_zero = 1'b0;
   endtask

   task automatic reset_parser();
      p_phase = PH_FIRST;
      p_status = STATUS_NONE;
      p_count = 8'd0;
      clear_token();
   endtask

   // Once the value no longer fits 64 bits it stays saturated.
   task automatic add_digit(input int d);
      logic [127:0] prod;
      if (!p_ovf) begin
         prod = 128'(p_acc) * 128'(cur_radix()) + 128'(d);
         if (prod[127:64] != 0) p_ovf = 1'b1;
         else p_acc = prod[63:0];
      end
   endtask

   task automatic start_digits(input logic [7:0] c);
      int d;
      d = char_digit(c);
      if (p_status == STATUS_NEG) begin
         if (d < 10) begin
            p_base = BASE_DEC;
            add_digit(d);
            p_prefix = PS_DIGITS;
         end else begin
            p_prefix = PS_DONE;
         end
      end else if (c == CHAR_ZERO) begin
         p_prefix = PS_ZERO;
      end else if (d < 10) begin
         p_base = BASE_DEC;
         add_digit(d);
         p_prefix = PS_DIGITS;
      end else begin
         p_prefix = PS_DONE;
      end
   endtask

   task automatic feed_token(input logic [7:0] c);
      int d;
      d = char_digit(c);
      // The hex marker is tracked over the whole token, not only its prefix.
      if (c == CHAR_LX && p_prev_zero) p_hex_seen = 1'b1;
      p_prev_zero = (c == CHAR_ZERO);
      case (p_prefix)
         PS_START: begin
            if (c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF || c == CHAR_CR) begin
            end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               p_minus = (c == CHAR_MINUS);
               p_prefix = PS_SIGNED;
            end else begin
               start_digits(c);
            end
         end
         PS_SIGNED: start_digits(c);
         PS_ZERO: begin
            if (c == CHAR_LX || c == CHAR_UX) begin
               p_prefix = PS_HEX0X;
            end else if (d < 8) begin
               p_base = BASE_OCT;
               add_digit(d);
               p_prefix = PS_DIGITS;
            end else begin
               p_prefix = PS_DONE;
            end
         end
         PS_HEX0X: begin
            if (d < 16) begin
               p_base = BASE_HEX;
               add_digit(d);
               p_prefix = PS_DIGITS;
            end else begin
               p_prefix = PS_DONE;
            end
         end
         PS_DIGITS: begin
            if (d < cur_radix()) add_digit(d);
            else p_prefix = PS_DONE;
         end
         default: ;
      endcase
   endtask

   function automatic logic [63:0] token_result();
      if (p_status == STATUS_NEG || p_hex_seen) begin
         if (p_minus) return (p_ovf || p_acc > MAG_NEG32) ? SAT_NEG32 : 64'd0 - p_acc;
         return (p_ovf || p_acc > SAT_POS32) ? SAT_POS32 : p_acc;
      end
      if (p_ovf) return ALL_ONES;
      return p_minus ? 64'd0 - p_acc : p_acc;
   endfunction

   function automatic line_result_type make_result(input logic hv, input logic [63:0] val,
                                                   input logic done);
      return '{p_status, hv, val, p_count, done};
   endfunction

   task automatic parse_char(input logic [7:0] c, input logic eob, output bit produced,
                             output line_result_type res);
      produced = 1'b0;
      res = '0;
      case (p_phase)
         PH_FIRST: begin
            p_count = 8'd0;
            clear_token();
            if (c == CHAR_O || c == CHAR_E) begin
               p_status = (c == CHAR_O) ? STATUS_POS : STATUS_NEG;
               if (eob) begin
                  produced = 1'b1;
                  res = make_result(1'b1, 64'd0, 1'b1);
               end else begin
                  p_phase = PH_STATUS;
               end
            end else begin
               produced = 1'b1;
               res = make_result(1'b0, 64'd0, 1'b1);
               p_phase = eob ? PH_FIRST : PH_DRAIN;
            end
         end
         PH_STATUS: begin
            if (c == CHAR_NL) begin
               produced = 1'b1;
               res = make_result(1'b1, 64'd0, 1'b1);
               p_phase = eob ? PH_FIRST : PH_DRAIN;
            end else if (c == CHAR_SP) begin
               clear_token();
               if (eob) begin
                  produced = 1'b1;
                  res = make_result(1'b1, 64'd0, 1'b1);
                  p_phase = PH_FIRST;
               end else begin
                  p_phase = PH_TOKENS;
               end
            end else if (eob) begin
               produced = 1'b1;
               res = make_result(1'b1, 64'd0, 1'b1);
               p_phase = PH_FIRST;
            end
         end
         PH_TOKENS: begin
            if (c == CHAR_NL) begin
               produced = 1'b1;
               res = make_result(1'b1, token_result(), 1'b1);
               p_phase = eob ? PH_FIRST : PH_DRAIN;
            end else if (c == CHAR_SP) begin
               produced = 1'b1;
               res = make_result(1'b1, token_result(), eob);
               if (p_count < 8'd255) p_count = p_count + 8'd1;
               clear_token();
               if (eob) p_phase = PH_FIRST;
            end else begin
               feed_token(c);
               if (eob) begin
                  produced = 1'b1;
                  res = make_result(1'b1, token_result(), 1'b1);
                  p_phase = PH_FIRST;
               end
            end
         end
         PH_DRAIN: if (eob) p_phase = PH_FIRST;
         default: p_phase = PH_FIRST;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Random buffer construction
   // ------------------------------------------------------------------------
   task automatic add_byte(input logic [7:0] b);
      line_bytes = {line_bytes, b};
   endtask

   task automatic add_row(input stim_row_type row);
      stim_rows = {stim_rows, row};
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if (c == CHAR_SP || c == CHAR_NL) c = "Q";
      return c;
   endfunction

   function automatic logic [7:0] hex_char();
      int d;
      d = $urandom_range(0, 21);
      if (d < 10) return 8'(48 + d);
      if (d < 16) return 8'(87 + d);
      return 8'(49 + d);
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 3))
         0: return CHAR_TAB;
         1: return CHAR_VT;
         2: return CHAR_FF;
         default: return CHAR_CR;
      endcase
   endfunction

   task automatic push_line(input bit eob_last);
      stim_row_type row;
      for (int k = 0; k < line_bytes.size(); k++) begin
         row = '0;
         row.ch = line_bytes[k];
         row.eob = eob_last && (k == line_bytes.size() - 1);
         add_row(row);
      end
      line_bytes.delete();
   endtask

   task automatic add_token();
      if ($urandom_range(0, 9) == 0) return;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 2)) add_byte(blank_char());
      end
      case ($urandom_range(0, 3))
         0: add_byte(CHAR_PLUS);
         1: add_byte(CHAR_MINUS);
         default: ;
      endcase
      case ($urandom_range(0, 5))
         0: repeat ($urandom_range(1, 6)) add_byte(8'("0" + $urandom_range(0, 9)));
         1: begin
            add_byte(CHAR_ZERO);
            repeat ($urandom_range(0, 8)) add_byte(8'("0" + $urandom_range(0, 8)));
         end
         2: begin
            add_byte(CHAR_ZERO);
            add_byte($urandom_range(0, 1) ? CHAR_LX : CHAR_UX);
            repeat ($urandom_range(0, 10)) add_byte(hex_char());
         end
         3: repeat ($urandom_range(15, 25)) add_byte(8'("0" + $urandom_range(0, 9)));
         4: begin
            add_byte(CHAR_ZERO);
            add_byte(CHAR_LX);
            repeat ($urandom_range(8, 18)) add_byte(hex_char());
         end
         default: repeat ($urandom_range(1, 4)) add_byte(plain_char());
      endcase
      // A trailing "0x" turns on 32-bit saturation for the whole token.
      case ($urandom_range(0, 9))
         0: add_byte(plain_char());
         1: begin
            add_byte(CHAR_ZERO);
            add_byte(CHAR_LX);
            add_byte("1");
         end
         default: ;
      endcase
   endtask

   task automatic build_buffer();
      logic [7:0] c;
      int         n;
      case ($urandom_range(0, 9))
         0: begin
            if ($urandom_range(0, 1)) add_byte($urandom_range(0, 1) ? CHAR_O : CHAR_E);
            repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
            push_line(1'b1);
         end
         1: begin
            c = plain_char();
            if (c == CHAR_O || c == CHAR_E) c = "#";
            add_byte(c);
            repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(0, 255)));
            push_line(1'b1);
         end
         default: begin
            add_byte($urandom_range(0, 1) ? CHAR_O : CHAR_E);
            repeat ($urandom_range(0, 4)) add_byte(8'("A" + $urandom_range(0, 25)));
            if ($urandom_range(0, 9) == 0) begin
               if ($urandom_range(0, 1)) add_byte(CHAR_NL);
               push_line(1'b1);
            end else begin
               add_byte(CHAR_SP);
               n = $urandom_range(0, 5);
               for (int t = 0; t < n; t++) begin
                  if (t > 0) begin
                     add_byte(CHAR_SP);
                     if ($urandom_range(0, 9) == 0) add_byte(CHAR_SP);
                  end
                  add_token();
               end
               case ($urandom_range(0, 2))
                  0: begin
                     add_byte(CHAR_NL);
                     repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
                  end
                  1: ;
                  default: add_byte(CHAR_SP);
               endcase
               push_line(1'b1);
            end
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Driving and checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic send_request(input stim_row_type row);
      int              gap;
      bit              produced;
      line_result_type predicted;
      gap = quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= row.ch;
      req_end_of_buffer <= row.eob;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      parse_char(row.ch, row.eob, produced, predicted);
      if (row.typed) expected_results = {expected_results, row.res};
      else if (produced) expected_results = {expected_results, predicted};
      @(negedge clock);
   endtask

   always @(posedge clock) begin : check_results
      line_result_type seen;
      line_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_resp_status, rsp_has_value, rsp_token_value, rsp_token_number,
                  rsp_line_done};
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result st=%0d hv=%0d val=%h num=%0d done=%0d",
                                      seen.status, seen.has_value, seen.value, seen.number,
                                      seen.done));
         end else begin
            want = expected_results.pop_front();
            if (seen.status !== want.status || seen.has_value !== want.has_value ||
                seen.value !== want.value || seen.number !== want.number ||
                seen.done !== want.done) begin
               report_mismatch($sformatf({"got st=%0d hv=%0d val=%h num=%0d done=%0d, ",
                                          "want st=%0d hv=%0d val=%h num=%0d done=%0d"},
                  seen.status, seen.has_value, seen.value, seen.number, seen.done,
                  want.status, want.has_value, want.value, want.number, want.done));
            end
         end
      end
   end

   // The receiver drops rsp_ready at random before each result, except in quiet stretches.
   initial begin : result_sink
      int stall;
      while (reset) @(negedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (reset) @(posedge clock);
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      directed_rows = '{
         '{"X",        1'b0, 1'b1, NO_STATUS_RESULT},
         '{"Z",        1'b1, 1'b0, '0},
         '{CHAR_E,     1'b1, 1'b1, NEG_ZERO_RESULT},
         '{CHAR_O,     1'b0, 1'b0, '0},
         '{CHAR_SP,    1'b0, 1'b0, '0},
         '{CHAR_ZERO,  1'b0, 1'b0, '0},
         '{CHAR_LX,    1'b0, 1'b0, '0},
         '{"f",        1'b0, 1'b0, '0},
         '{CHAR_SP,    1'b0, 1'b0, '0},
         '{CHAR_SP,    1'b0, 1'b0, '0},
         '{CHAR_TAB,   1'b0, 1'b0, '0},
         '{CHAR_MINUS, 1'b0, 1'b0, '0},
         '{"7",        1'b0, 1'b0, '0},
         '{CHAR_SP,    1'b0, 1'b0, '0},
         '{CHAR_ZERO,  1'b0, 1'b0, '0},
         '{CHAR_LX,    1'b0, 1'b0, '0},
         '{CHAR_NL,    1'b0, 1'b0, '0},
         '{8'hFF,      1'b1, 1'b0, '0},
         '{CHAR_E,     1'b0, 1'b0, '0},
         '{"R",        1'b0, 1'b0, '0},
         '{CHAR_NL,    1'b1, 1'b1, NEG_ZERO_RESULT},
         '{CHAR_E,     1'b0, 1'b0, '0},
         '{CHAR_SP,    1'b0, 1'b0, '0},
         '{8'h00,      1'b0, 1'b0, '0},
         '{CHAR_SP,    1'b1, 1'b1, NEG_ZERO_RESULT}
      };
      foreach (directed_rows[i]) add_row(directed_rows[i]);

      // One line with more than 255 tokens, so the token number saturates.
      add_byte(CHAR_O);
      repeat (300) add_byte(CHAR_SP);
      add_byte("5");
      push_line(1'b1);
      while (stim_rows.size() < DIRECTED_ROWS + RANDOM_ITEMS) build_buffer();

      reset_parser();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < stim_rows.size(); i++) begin
         if (i % 150 == 0) quiet = ($urandom_range(0, 2) == 0);
         send_request(stim_rows[i]);
      end
      req_valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- response_line_number_parser_top.f -----
design/rlnp_pkg.sv
design/response_line_number_parser_top.sv
sim/tb_top.sv
